[hw/rtl/q2e_pkg.sv]
// package: payload types and constants for the quaternion to euler unit
`default_nettype none
package q2e_pkg;

    // input transaction payload
    typedef struct packed {
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } quat_t;

    // result transaction payload
    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
        logic               pitch_saturated;
    } euler_t;

    // angle accumulator width, 2^31 equals pi
    localparam int ANGLE_W = 32;
    // cordic datapath width
    localparam int CW = 68;
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;
    localparam logic signed [67:0] ONE_Q30 = 68'sd1 <<< 30;

    // atan(2^-i), 2^31 equals pi
    function automatic logic [31:0] atan_lut(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051E;
            5'd2: r = 32'h09FB385B;  5'd3: r = 32'h051111D4;
            5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
            5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;
            5'd8: r = 32'h0028BE53;  5'd9: r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
            5'd30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/q2e_cordic_stage.sv]
// module: one registered vectoring cordic rotation for three angle lanes
`default_nettype none
module q2e_cordic_stage #(
    parameter int STAGE = 0
) (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire logic signed [3*q2e_pkg::CW-1:0] x_in,
    input  wire logic signed [3*q2e_pkg::CW-1:0] y_in,
    input  wire logic        [3*32-1:0]        z_in,
    output logic signed      [3*q2e_pkg::CW-1:0] x_out,
    output logic signed      [3*q2e_pkg::CW-1:0] y_out,
    output logic             [3*32-1:0]        z_out
);
    import q2e_pkg::*;

    localparam logic [4:0] IDX = 5'(STAGE);
    localparam logic [31:0] ATAN = atan_lut(IDX);

    logic signed [CW-1:0] x_reg [3];
    logic signed [CW-1:0] y_reg [3];
    logic        [31:0]   z_reg [3];
    logic signed [CW-1:0] xi [3];
    logic signed [CW-1:0] yi [3];

    // lane inputs split out of the packed buses
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            xi[k] = signed'(x_in[k*CW +: CW]);
            yi[k] = signed'(y_in[k*CW +: CW]);
        end
    end

    // per lane micro rotation, direction from the sign of y
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                if (!yi[k][CW-1]) begin
                    x_reg[k] <= xi[k] + (yi[k] >>> STAGE);
                    y_reg[k] <= yi[k] - (xi[k] >>> STAGE);
                    z_reg[k] <= z_in[k*32 +: 32] + ATAN;
                end else begin
                    x_reg[k] <= xi[k] - (yi[k] >>> STAGE);
                    y_reg[k] <= yi[k] + (xi[k] >>> STAGE);
                    z_reg[k] <= z_in[k*32 +: 32] - ATAN;
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            x_out[k*CW +: CW] = x_reg[k];
            y_out[k*CW +: CW] = y_reg[k];
            z_out[k*32 +: 32] = z_reg[k];
        end
    end
endmodule
`default_nettype wire

[hw/rtl/quaternion_to_euler_unit.sv]
// top level: quaternion to z-y-x euler angle conversion pipeline
//
//  channel | direction | ports                 | payload
//  s_      | in        | s_valid s_ready s_data | q2e_pkg::quat_t
//  m_      | out       | m_valid m_ready m_data | q2e_pkg::euler_t
//
// one transaction enters per cycle unless the output stalls; 36 + CORDIC_STAGES
// register stages: 3 product stages, 31 square root stages (one result bit each),
// 1 prescale stage, CORDIC_STAGES rotation stages and 1 output stage.
// the whole pipeline advances on a common enable that is low only when the
// output register holds a transaction that is not taken, so ready follows m_ready
// or an empty output. reset clears only the valid bits.
`default_nettype none
module quaternion_to_euler_unit #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire q2e_pkg::quat_t    s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output q2e_pkg::euler_t        m_data
);
    import q2e_pkg::*;

    localparam int SQ = 31;
    localparam int DEPTH = 3 + SQ + 1 + CORDIC_STAGES;

    logic en;
    logic [DEPTH-1:0] vld_reg;

    assign en = !m_valid || m_ready;
    assign s_ready = en;

    // valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            m_valid <= 1'b0;
        end else if (en) begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_valid};
            m_valid <= vld_reg[DEPTH-1];
        end
    end

    // stage 1: ten products
    logic signed [31:0] p_reg [10];
    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg[0] <= s_data.quat_w * s_data.quat_x;
            p_reg[1] <= s_data.quat_y * s_data.quat_z;
            p_reg[2] <= s_data.quat_x * s_data.quat_x;
            p_reg[3] <= s_data.quat_y * s_data.quat_y;
            p_reg[4] <= s_data.quat_w * s_data.quat_y;
            p_reg[5] <= s_data.quat_z * s_data.quat_x;
            p_reg[6] <= s_data.quat_w * s_data.quat_z;
            p_reg[7] <= s_data.quat_x * s_data.quat_y;
            p_reg[8] <= s_data.quat_z * s_data.quat_z;
            p_reg[9] <= s_data.quat_y * s_data.quat_y;
        end
    end

    // stage 2: products combined into sines and cosines
    logic signed [35:0] sr_reg, cr_reg, sp_reg, sy_reg, cy_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            sr_reg <= 36'(2 * (36'(p_reg[0]) + 36'(p_reg[1])));
            cr_reg <= 36'(ONE_Q30) - 36'(2 * (36'(p_reg[2]) + 36'(p_reg[3])));
            sp_reg <= 36'(2 * (36'(p_reg[4]) - 36'(p_reg[5])));
            sy_reg <= 36'(2 * (36'(p_reg[6]) + 36'(p_reg[7])));
            cy_reg <= 36'(ONE_Q30) - 36'(2 * (36'(p_reg[8]) + 36'(p_reg[9])));
        end
    end

    // stage 3: saturation test and 1 - s*s
    // an unsaturated sine term fits in 31 signed bits
    logic signed [35:0] sr3_reg, cr3_reg, sp3_reg, sy3_reg, cy3_reg;
    logic               sat3_reg;
    logic        [60:0] rem3_reg;
    logic               sat_c;
    logic signed [30:0] sp_lo_c;
    logic signed [61:0] sq_c;
    always_comb begin
        sat_c   = (sp_reg >= 36'(ONE_Q30)) || (sp_reg <= -36'(ONE_Q30));
        sp_lo_c = 31'(sp_reg);
        sq_c    = sp_lo_c * sp_lo_c;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            sr3_reg <= sr_reg; cr3_reg <= cr_reg; sp3_reg <= sp_reg;
            sy3_reg <= sy_reg; cy3_reg <= cy_reg; sat3_reg <= sat_c;
            rem3_reg <= sat_c ? 61'd0 : (61'd1 << 60) - 61'(sq_c);
        end
    end

    // square root pipeline, one result bit per stage
    logic [60:0] n_reg   [SQ+1];
    logic [61:0] r_reg   [SQ+1];
    logic signed [35:0] qs_reg [SQ+1][4];
    logic        qsat_reg [SQ+1];
    assign n_reg[0] = rem3_reg;
    assign r_reg[0] = '0;
    assign qs_reg[0][0] = sr3_reg;
    assign qs_reg[0][1] = cr3_reg;
    assign qs_reg[0][2] = sp3_reg;
    assign qs_reg[0][3] = sy3_reg;
    assign qsat_reg[0] = sat3_reg;
    logic signed [35:0] cyq_reg [SQ+1];
    assign cyq_reg[0] = cy3_reg;
    for (genvar g = 0; g < SQ; g++) begin : g_sqrt
        localparam logic [61:0] BIT = 62'd1 << (60 - 2 * g);
        logic [61:0] t;
        assign t = r_reg[g] + BIT;
        always_ff @(posedge aclk) begin
            if (en) begin
                if ({1'b0, n_reg[g]} >= t) begin
                    n_reg[g+1] <= 61'({1'b0, n_reg[g]} - t);
                    r_reg[g+1] <= (r_reg[g] >> 1) + BIT;
                end else begin
                    n_reg[g+1] <= n_reg[g];
                    r_reg[g+1] <= r_reg[g] >> 1;
                end
                qs_reg[g+1] <= qs_reg[g];
                cyq_reg[g+1] <= cyq_reg[g];
                qsat_reg[g+1] <= qsat_reg[g];
            end
        end
    end

    // prescale: zero sine and left half plane handling per lane
    logic signed [3*CW-1:0] cx0, cy0;
    logic        [3*32-1:0] cz0;
    logic        [2:0]      zero_reg, neg_reg;
    logic                   sat_p_reg, spos_p_reg;
    logic signed [35:0] ys [3];
    logic signed [35:0] xs [3];
    always_comb begin
        ys[0] = qs_reg[SQ][0]; xs[0] = qs_reg[SQ][1];
        ys[1] = qs_reg[SQ][2]; xs[1] = 36'(r_reg[SQ]);
        ys[2] = qs_reg[SQ][3]; xs[2] = cyq_reg[SQ];
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                zero_reg[k] <= (ys[k] == '0);
                neg_reg[k]  <= xs[k][35];
                if (xs[k][35]) begin
                    cx0[k*CW +: CW] <= -CW'(xs[k]);
                    cy0[k*CW +: CW] <= -CW'(ys[k]);
                    cz0[k*32 +: 32] <= HALF_TURN;
                end else begin
                    cx0[k*CW +: CW] <= CW'(xs[k]);
                    cy0[k*CW +: CW] <= CW'(ys[k]);
                    cz0[k*32 +: 32] <= '0;
                end
            end
            sat_p_reg  <= qsat_reg[SQ];
            spos_p_reg <= !qs_reg[SQ][2][35];
        end
    end

    // cordic rotation stages with side flags delayed alongside
    logic signed [3*CW-1:0] cx [CORDIC_STAGES+1];
    logic signed [3*CW-1:0] cyv [CORDIC_STAGES+1];
    logic        [3*32-1:0] cz [CORDIC_STAGES+1];
    logic [2:0] zf [CORDIC_STAGES+1];
    logic [2:0] nf [CORDIC_STAGES+1];
    logic       sf [CORDIC_STAGES+1];
    logic       pf [CORDIC_STAGES+1];
    assign cx[0] = cx0; assign cyv[0] = cy0; assign cz[0] = cz0;
    assign zf[0] = zero_reg; assign nf[0] = neg_reg;
    assign sf[0] = sat_p_reg; assign pf[0] = spos_p_reg;
    for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cordic
        q2e_cordic_stage #(.STAGE(s < 32 ? s : 31)) u_stage (
            .aclk(aclk), .en(en),
            .x_in(cx[s]), .y_in(cyv[s]), .z_in(cz[s]),
            .x_out(cx[s+1]), .y_out(cyv[s+1]), .z_out(cz[s+1])
        );
        always_ff @(posedge aclk) begin
            if (en) begin
                zf[s+1] <= zf[s]; nf[s+1] <= nf[s];
                sf[s+1] <= sf[s]; pf[s+1] <= pf[s];
            end
        end
    end

    // output: rounding, special cases, pitch clamp
    logic [31:0] ang [3];
    logic [15:0] rnd [3];
    logic signed [15:0] pitch_c;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (zf[CORDIC_STAGES][k])
                ang[k] = nf[CORDIC_STAGES][k] ? HALF_TURN : 32'd0;
            else
                ang[k] = cz[CORDIC_STAGES][k*32 +: 32];
            rnd[k] = 16'((ang[k] + 32'h8000) >> 16);
        end
        if (sf[CORDIC_STAGES])
            pitch_c = pf[CORDIC_STAGES] ? 16'sd16384 : -16'sd16384;
        else if (signed'(rnd[1]) > 16'sd16384)
            pitch_c = 16'sd16384;
        else if (signed'(rnd[1]) < -16'sd16384)
            pitch_c = -16'sd16384;
        else
            pitch_c = signed'(rnd[1]);
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            m_data.roll_angle      <= signed'(rnd[0]);
            m_data.pitch_angle     <= pitch_c;
            m_data.yaw_angle       <= signed'(rnd[2]);
            m_data.pitch_saturated <= sf[CORDIC_STAGES];
        end
    end
endmodule
`default_nettype wire
